>>> rtl/core/rwfsp_pkg.sv
package rwfsp_pkg;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA    = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FORMAT_FLOAT = 16'd3;
  localparam logic [15:0] FLOAT_BITS   = 16'd32;
  localparam logic [15:0] MONO         = 16'd1;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_FMT_SMALL = 3'd2,
    ERR_NO_FMT    = 3'd3,
    ERR_NOT_MONO  = 3'd4,
    ERR_NOT_F32   = 3'd5,
    ERR_TRUNC     = 3'd6
  } err_t;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

endpackage

>>> rtl/core/riff_wave_float_stream_parser_unit.sv
// each accepted input word gives its result word on the out side in the next cycle
// throughput: one input word per cycle while out_tready is high; the output register
// is refilled in the cycle it is taken
// reset: synchronous active-low rst_n; parser returns to the riff magic, errors and
// fmt fields clear, output register empties
module riff_wave_float_stream_parser_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rwfsp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] byte_value
  input  logic                               in_tlast,   // stream_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] sample_bits, [32] header_done, [64:33] sample_rate, [67:65] error_code
  output logic [rwfsp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast,  // sample_last
  output logic                               out_tuser   // sample_valid
);

  typedef enum logic [3:0] {
    PH_RIFF     = 4'd0,
    PH_RSIZE    = 4'd1,
    PH_WAVE     = 4'd2,
    PH_ID       = 4'd3,
    PH_SZ_FMT   = 4'd4,
    PH_SZ_DATA  = 4'd5,
    PH_SZ_OTHER = 4'd6,
    PH_FMT_BODY = 4'd7,
    PH_SKIP     = 4'd8,
    PH_DATA     = 4'd9,
    PH_DONE     = 4'd10,
    PH_ERROR    = 4'd11
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] fmt_tag_r, fmt_tag_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] bps_r, bps_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] left_r, left_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        magic_bad_r, magic_bad_nxt;

  logic        ov_r;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] obits_r, obits_nxt;
  logic        olast_r, olast_nxt;
  logic        odone_r;
  logic [31:0] orate_r;
  logic [2:0]  oerr_r;

  logic        accept;
  logic [7:0]  byte_in;

  assign in_tready = !ov_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign byte_in   = in_tdata[7:0];

  always_comb begin
    logic [31:0] w;
    logic [3:0]  cnt_inc;
    logic [3:0]  p;
    logic [32:0] skip_dec;
    logic [32:0] skip_n;
    logic [31:0] left_dec;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        do_skip;

    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    gather_nxt    = gather_r;
    skip_nxt      = skip_r;
    fmt_seen_nxt  = fmt_seen_r;
    fmt_tag_nxt   = fmt_tag_r;
    chan_nxt      = chan_r;
    bps_nxt       = bps_r;
    rate_nxt      = rate_r;
    left_nxt      = left_r;
    err_nxt       = err_r;
    magic_bad_nxt = magic_bad_r;
    ovalid_nxt    = 1'b0;
    obits_nxt     = 32'd0;
    olast_nxt     = 1'b0;
    do_fail       = 1'b0;
    fail_code     = rwfsp_pkg::ERR_NONE;
    do_skip       = 1'b0;
    skip_n        = 33'd0;

    w        = gather_r | (32'(byte_in) << {cnt_r[1:0], 3'b000});
    cnt_inc  = cnt_r + 4'd1;
    p        = cnt_r;
    skip_dec = skip_r - 33'd1;
    left_dec = left_r - 32'd1;

    if (in_tlast) begin
      if (phase_r == PH_DATA) begin
        phase_nxt = PH_DONE;
      end else if (phase_r <= PH_SKIP) begin
        do_fail   = 1'b1;
        fail_code = rwfsp_pkg::ERR_TRUNC;
      end
    end else if (phase_r <= PH_SZ_OTHER) begin
      if (cnt_inc >= 4'd4) begin
        gather_nxt = 32'd0;
        cnt_nxt    = 4'd0;
        unique case (phase_r)
          PH_RIFF: begin
            magic_bad_nxt = (w != rwfsp_pkg::MAGIC_RIFF);
            phase_nxt     = PH_RSIZE;
          end
          PH_RSIZE: phase_nxt = PH_WAVE;
          PH_WAVE: begin
            if (magic_bad_r || w != rwfsp_pkg::MAGIC_WAVE) begin
              do_fail   = 1'b1;
              fail_code = rwfsp_pkg::ERR_MAGIC;
            end else begin
              phase_nxt = PH_ID;
            end
          end
          PH_ID: begin
            if (w == rwfsp_pkg::ID_FMT)       phase_nxt = PH_SZ_FMT;
            else if (w == rwfsp_pkg::ID_DATA) phase_nxt = PH_SZ_DATA;
            else                              phase_nxt = PH_SZ_OTHER;
          end
          PH_SZ_FMT: begin
            if (w < rwfsp_pkg::FMT_BODY_LEN) begin
              do_fail   = 1'b1;
              fail_code = rwfsp_pkg::ERR_FMT_SMALL;
            end else begin
              skip_nxt  = {1'b0, w - rwfsp_pkg::FMT_BODY_LEN};
              phase_nxt = PH_FMT_BODY;
            end
          end
          PH_SZ_DATA: begin
            if (!fmt_seen_r) begin
              do_fail   = 1'b1;
              fail_code = rwfsp_pkg::ERR_NO_FMT;
            end else if (chan_r != rwfsp_pkg::MONO) begin
              do_fail   = 1'b1;
              fail_code = rwfsp_pkg::ERR_NOT_MONO;
            end else if (fmt_tag_r != rwfsp_pkg::FORMAT_FLOAT
                         || bps_r != rwfsp_pkg::FLOAT_BITS) begin
              do_fail   = 1'b1;
              fail_code = rwfsp_pkg::ERR_NOT_F32;
            end else begin
              left_nxt  = w;
              phase_nxt = (w == 32'd0) ? PH_DONE : PH_DATA;
            end
          end
          default: begin
            do_skip = 1'b1;
            skip_n  = {1'b0, w} + {32'd0, w[0]};
          end
        endcase
      end else begin
        gather_nxt = w;
        cnt_nxt    = cnt_inc;
      end
    end else if (phase_r == PH_FMT_BODY) begin
      if (p < 4'd2) begin
        if (p[0]) fmt_tag_nxt[15:8] = byte_in;
        else      fmt_tag_nxt[7:0]  = byte_in;
      end else if (p < 4'd4) begin
        if (p[0]) chan_nxt[15:8] = byte_in;
        else      chan_nxt[7:0]  = byte_in;
      end else if (p < 4'd8) begin
        case (p[1:0])
          2'd0:    rate_nxt[7:0]   = byte_in;
          2'd1:    rate_nxt[15:8]  = byte_in;
          2'd2:    rate_nxt[23:16] = byte_in;
          default: rate_nxt[31:24] = byte_in;
        endcase
      end else if (p >= 4'd14) begin
        if (p[0]) bps_nxt[15:8] = byte_in;
        else      bps_nxt[7:0]  = byte_in;
      end
      if (p == 4'd15) begin
        cnt_nxt      = 4'd0;
        fmt_seen_nxt = 1'b1;
        do_skip      = 1'b1;
        skip_n       = skip_r;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end else if (phase_r == PH_SKIP) begin
      if (skip_r != 33'd0) skip_nxt = skip_dec;
      if (skip_r <= 33'd1) phase_nxt = PH_ID;
    end else if (phase_r == PH_DATA) begin
      left_nxt = left_dec;
      if (cnt_inc >= 4'd4) begin
        ovalid_nxt = 1'b1;
        obits_nxt  = w;
        olast_nxt  = (left_dec < 32'd4);
        gather_nxt = 32'd0;
        cnt_nxt    = 4'd0;
      end else begin
        gather_nxt = w;
        cnt_nxt    = cnt_inc;
      end
      if (left_dec == 32'd0) begin
        phase_nxt  = PH_DONE;
        gather_nxt = 32'd0;
        cnt_nxt    = 4'd0;
      end
    end

    if (do_skip) begin
      skip_nxt  = skip_n;
      phase_nxt = (skip_n == 33'd0) ? PH_ID : PH_SKIP;
    end

    if (do_fail) begin
      err_nxt   = fail_code;
      phase_nxt = PH_ERROR;
      rate_nxt  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      cnt_r       <= 4'd0;
      gather_r    <= 32'd0;
      skip_r      <= 33'd0;
      fmt_seen_r  <= 1'b0;
      fmt_tag_r   <= 16'd0;
      chan_r      <= 16'd0;
      bps_r       <= 16'd0;
      rate_r      <= 32'd0;
      left_r      <= 32'd0;
      err_r       <= rwfsp_pkg::ERR_NONE;
      magic_bad_r <= 1'b0;
      ov_r        <= 1'b0;
      ovalid_r    <= 1'b0;
      obits_r     <= 32'd0;
      olast_r     <= 1'b0;
      odone_r     <= 1'b0;
      orate_r     <= 32'd0;
      oerr_r      <= rwfsp_pkg::ERR_NONE;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        gather_r    <= gather_nxt;
        skip_r      <= skip_nxt;
        fmt_seen_r  <= fmt_seen_nxt;
        fmt_tag_r   <= fmt_tag_nxt;
        chan_r      <= chan_nxt;
        bps_r       <= bps_nxt;
        rate_r      <= rate_nxt;
        left_r      <= left_nxt;
        err_r       <= err_nxt;
        magic_bad_r <= magic_bad_nxt;
        ov_r        <= 1'b1;
        ovalid_r    <= ovalid_nxt;
        obits_r     <= obits_nxt;
        olast_r     <= olast_nxt;
        odone_r     <= (phase_nxt == PH_DATA) || (phase_nxt == PH_DONE);
        orate_r     <= rate_nxt;
        oerr_r      <= err_nxt;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oerr_r, orate_r, odone_r, obits_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = ovalid_r;

endmodule

>>> bench/tb_riff_wave_float_stream_parser_unit.sv
`timescale 1ns / 100ps

module tb_riff_wave_float_stream_parser_unit;

  typedef enum logic [3:0] {
    PS_RIFF, PS_RSIZE, PS_WAVE, PS_ID, PS_SZ_FMT, PS_SZ_DATA, PS_SZ_OTHER,
    PS_FMT_BODY, PS_SKIP, PS_DATA, PS_DONE, PS_ERROR
  } hdr_phase_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] bits;
    logic        last;
    logic        done;
    logic [31:0] rate;
    logic [2:0]  err;
  } wav_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    logic        typed;
    wav_result_t want;
  } probe_row_t;

  // no sample, no header, no rate, no error
  localparam wav_result_t QUIET_RES = '0;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [rwfsp_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                              in_tlast;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [rwfsp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tlast;
  logic                              out_tuser;

  wav_result_t parser_out_q [$];
  int          mismatch_cnt = 0;
  int          words_seen = 0;
  logic        calm = 1'b0;

  // parser shadow state
  hdr_phase_t  pv_phase = PS_RIFF;
  logic [3:0]  pv_fcnt = '0;
  logic [31:0] pv_gather = '0;
  logic [32:0] pv_skip = '0;
  logic        pv_fmt_seen = 1'b0;
  logic [15:0] pv_tag = '0;
  logic [15:0] pv_chans = '0;
  logic [15:0] pv_bps = '0;
  logic [31:0] pv_rate = '0;
  logic [31:0] pv_data_left = '0;
  logic [2:0]  pv_err = '0;
  logic        pv_magic_bad = 1'b0;

  // riff magic, riff size at its maximum, wave magic, odd-sized unknown chunk with pad
  probe_row_t opening [0:21] = '{
    '{8'h52, 1'b0, 1'b1, QUIET_RES}, '{8'h49, 1'b0, 1'b1, QUIET_RES},
    '{8'h46, 1'b0, 1'b1, QUIET_RES}, '{8'h46, 1'b0, 1'b1, QUIET_RES},
    '{8'hFF, 1'b0, 1'b1, QUIET_RES}, '{8'hFF, 1'b0, 1'b1, QUIET_RES},
    '{8'hFF, 1'b0, 1'b1, QUIET_RES}, '{8'hFF, 1'b0, 1'b1, QUIET_RES},
    '{8'h57, 1'b0, 1'b1, QUIET_RES}, '{8'h41, 1'b0, 1'b1, QUIET_RES},
    '{8'h56, 1'b0, 1'b1, QUIET_RES}, '{8'h45, 1'b0, 1'b1, QUIET_RES},
    '{8'h4C, 1'b0, 1'b1, QUIET_RES}, '{8'h49, 1'b0, 1'b1, QUIET_RES},
    '{8'h53, 1'b0, 1'b1, QUIET_RES}, '{8'h54, 1'b0, 1'b1, QUIET_RES},
    '{8'h01, 1'b0, 1'b1, QUIET_RES}, '{8'h00, 1'b0, 1'b1, QUIET_RES},
    '{8'h00, 1'b0, 1'b1, QUIET_RES}, '{8'h00, 1'b0, 1'b1, QUIET_RES},
    '{8'h00, 1'b0, 1'b0, QUIET_RES}, '{8'hFF, 1'b0, 1'b0, QUIET_RES}
  };

  riff_wave_float_stream_parser_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void set_fault(input rwfsp_pkg::err_t code);
    pv_err = code;
    pv_phase = PS_ERROR;
    pv_rate = '0;
  endfunction

  function automatic void begin_skip(input logic [32:0] n);
    pv_skip = n;
    pv_phase = (n == 0) ? PS_ID : PS_SKIP;
  endfunction

  function automatic wav_result_t parse_wav_byte(input logic [7:0] b, input logic e);
    wav_result_t r;
    logic [31:0] w;
    int p;
    r = QUIET_RES;
    if (e) begin
      if (pv_phase == PS_DATA) pv_phase = PS_DONE;
      else if (pv_phase <= PS_SKIP) set_fault(rwfsp_pkg::ERR_TRUNC);
    end else if (pv_phase <= PS_SZ_OTHER) begin
      pv_gather = pv_gather | (32'(b) << (8 * pv_fcnt[1:0]));
      pv_fcnt = pv_fcnt + 4'd1;
      if (pv_fcnt >= 4'd4) begin
        w = pv_gather;
        pv_gather = '0;
        pv_fcnt = '0;
        case (pv_phase)
          PS_RIFF: begin
            pv_magic_bad = (w != rwfsp_pkg::MAGIC_RIFF);
            pv_phase = PS_RSIZE;
          end
          PS_RSIZE: pv_phase = PS_WAVE;
          PS_WAVE: begin
            if (pv_magic_bad || w != rwfsp_pkg::MAGIC_WAVE) set_fault(rwfsp_pkg::ERR_MAGIC);
            else pv_phase = PS_ID;
          end
          PS_ID: begin
            pv_phase = (w == rwfsp_pkg::ID_FMT) ? PS_SZ_FMT :
                       (w == rwfsp_pkg::ID_DATA) ? PS_SZ_DATA : PS_SZ_OTHER;
          end
          PS_SZ_FMT: begin
            if (w < rwfsp_pkg::FMT_BODY_LEN) set_fault(rwfsp_pkg::ERR_FMT_SMALL);
            else begin
              pv_skip = 33'(w - rwfsp_pkg::FMT_BODY_LEN);
              pv_phase = PS_FMT_BODY;
            end
          end
          PS_SZ_DATA: begin
            if (!pv_fmt_seen) set_fault(rwfsp_pkg::ERR_NO_FMT);
            else if (pv_chans != rwfsp_pkg::MONO) set_fault(rwfsp_pkg::ERR_NOT_MONO);
            else if (pv_tag != rwfsp_pkg::FORMAT_FLOAT || pv_bps != rwfsp_pkg::FLOAT_BITS)
              set_fault(rwfsp_pkg::ERR_NOT_F32);
            else begin
              pv_data_left = w;
              pv_phase = (w == 0) ? PS_DONE : PS_DATA;
            end
          end
          default: begin_skip({1'b0, w} + 33'(w[0]));
        endcase
      end
    end else if (pv_phase == PS_FMT_BODY) begin
      p = int'(pv_fcnt);
      if (p < 2) pv_tag[8 * (p % 2) +: 8] = b;
      else if (p < 4) pv_chans[8 * (p % 2) +: 8] = b;
      else if (p < 8) pv_rate[8 * (p - 4) +: 8] = b;
      else if (p >= 14) pv_bps[8 * (p % 2) +: 8] = b;
      if (p == 15) begin
        pv_fcnt = '0;
        pv_fmt_seen = 1'b1;
        begin_skip(pv_skip);
      end else begin
        pv_fcnt = 4'(p + 1);
      end
    end else if (pv_phase == PS_SKIP) begin
      if (pv_skip != 0) pv_skip = pv_skip - 33'd1;
      if (pv_skip == 0) pv_phase = PS_ID;
    end else if (pv_phase == PS_DATA) begin
      pv_gather = pv_gather | (32'(b) << (8 * pv_fcnt[1:0]));
      pv_fcnt = pv_fcnt + 4'd1;
      pv_data_left = pv_data_left - 32'd1;
      if (pv_fcnt >= 4'd4) begin
        r.valid = 1'b1;
        r.bits = pv_gather;
        r.last = (pv_data_left < 32'd4);
        pv_gather = '0;
        pv_fcnt = '0;
      end
      if (pv_data_left == 0) begin
        pv_phase = PS_DONE;
        pv_gather = '0;
        pv_fcnt = '0;
      end
    end
    r.done = (pv_phase == PS_DATA || pv_phase == PS_DONE);
    r.rate = pv_rate;
    r.err = pv_err;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic e, input logic typed,
                           input wav_result_t want);
    wav_result_t r;
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = parse_wav_byte(b, e);
    parser_out_q.push_back(typed ? want : r);
  endtask

  task automatic send_le32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8 * i +: 8], 1'b0, 1'b0, QUIET_RES);
  endtask

  task automatic send_junk_chunk();
    logic [31:0] id;
    int len;
    do id = $urandom; while (id == rwfsp_pkg::ID_FMT || id == rwfsp_pkg::ID_DATA);
    len = $urandom_range(0, 9);
    send_le32(id);
    send_le32(len);
    repeat (len + len % 2) push_byte(8'($urandom), 1'b0, 1'b0, QUIET_RES);
  endtask

  // a bad fmt chunk is always followed by a good one that overwrites it
  task automatic send_fmt(input logic good);
    logic [15:0] tag, chans, bps;
    int extra;
    extra = good ? $urandom_range(0, 3) : $urandom_range(0, 4);
    tag = good ? rwfsp_pkg::FORMAT_FLOAT : 16'($urandom);
    chans = good ? rwfsp_pkg::MONO : 16'($urandom);
    bps = good ? rwfsp_pkg::FLOAT_BITS : 16'($urandom);
    send_le32(rwfsp_pkg::ID_FMT);
    send_le32(rwfsp_pkg::FMT_BODY_LEN + 32'(extra));
    send_le32({chans, tag});
    send_le32($urandom);
    send_le32($urandom);
    send_le32({bps, 16'($urandom)});
    repeat (extra) push_byte(8'($urandom), 1'b0, 1'b0, QUIET_RES);
  endtask

  task automatic log_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("%s", msg);
    mismatch_cnt++;
  endtask

  initial begin
    int n, dsize, nsend;
    logic early;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening[i])
      push_byte(opening[i].b, opening[i].e, opening[i].typed, opening[i].want);
    n = $urandom_range(0, 2);
    repeat (n) send_junk_chunk();
    if ($urandom_range(0, 1) == 1) send_fmt(1'b0);
    send_fmt(1'b1);
    n = $urandom_range(0, 2);
    repeat (n) send_junk_chunk();
    send_le32(rwfsp_pkg::ID_DATA);
    dsize = $urandom_range(1000, 1063);
    send_le32(dsize);
    // either the stream ends inside the data chunk or the chunk runs out first
    early = 1'($urandom_range(0, 1));
    nsend = early ? dsize - $urandom_range(1, 9) : dsize;
    for (int i = 0; i < nsend; i++) begin
      if (nsend - i < 150) calm = 1'b1;
      push_byte((i < 4) ? 8'h00 : (i < 8) ? 8'hFF : 8'($urandom), 1'b0, 1'b0, QUIET_RES);
    end
    n = $urandom_range(1, 4);
    repeat (n) push_byte(8'($urandom), 1'b0, 1'b0, QUIET_RES);
    push_byte(8'($urandom), 1'b1, 1'b0, QUIET_RES);
    repeat (2) push_byte(8'($urandom), 1'b0, 1'b0, QUIET_RES);
    push_byte(8'($urandom), 1'b1, 1'b0, QUIET_RES);
    in_tvalid <= 1'b0;
    while (parser_out_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[riff_wave_float_stream_parser_unit] OK");
    end else begin
      $display("[riff_wave_float_stream_parser_unit] ERROR");
    end
    $finish;
  end

  initial begin : sink
    int hold;
    wav_result_t got, exp_res;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.valid = out_tuser;
        got.bits = out_tdata[31:0];
        got.last = out_tlast;
        got.done = out_tdata[32];
        got.rate = out_tdata[64:33];
        got.err = out_tdata[67:65];
        if (parser_out_q.size() == 0) begin
          log_mismatch($sformatf(
            "unexpected word: valid=%b bits=%h last=%b done=%b rate=%h err=%0d",
            got.valid, got.bits, got.last, got.done, got.rate, got.err));
        end else begin
          exp_res = parser_out_q.pop_front();
          if (got.valid !== exp_res.valid || got.bits !== exp_res.bits ||
              got.last !== exp_res.last || got.done !== exp_res.done ||
              got.rate !== exp_res.rate || got.err !== exp_res.err) begin
            log_mismatch($sformatf({
              "word %0d: exp valid=%b bits=%h last=%b done=%b rate=%h err=%0d, ",
              "got valid=%b bits=%h last=%b done=%b rate=%h err=%0d"},
              words_seen, exp_res.valid, exp_res.bits, exp_res.last, exp_res.done,
              exp_res.rate, exp_res.err, got.valid, got.bits, got.last, got.done,
              got.rate, got.err));
          end
        end
        words_seen++;
        // long hold-off so the output stage fills and in_tready drops
        if (words_seen == 300) hold = 60;
      end
      if (hold == 0 && !calm && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 16);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[riff_wave_float_stream_parser_unit] ERROR");
    $finish;
  end

endmodule
